// ===== sv/mpes_pkg.sv =====
// Shared types, constants and a helper function for the MPEG-1 packet header parser.
`default_nettype none
package mpes_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TYPE_W    = 3;
    localparam int unsigned SUB_W     = 5;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned BUF_W     = 23;
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned HDR_W     = 16;
    localparam int unsigned PAY_W     = 32;
    localparam int unsigned SHIFT_W   = 40;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned OUT_DATA_W = 184;

    // Stream type codes.
    localparam logic [TYPE_W-1:0] TYPE_AUDIO   = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_VIDEO   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_PRIVATE = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_PADDING = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_OTHER   = 3'd4;

    // Stream id values of interest.
    localparam logic [BYTE_W-1:0] ID_PRIVATE1 = 8'hBD;
    localparam logic [BYTE_W-1:0] ID_PADDING  = 8'hBE;
    localparam logic [BYTE_W-1:0] ID_PRIVATE2 = 8'hBF;
    localparam logic [BYTE_W-1:0] ID_AUDIO_LO = 8'hC0;
    localparam logic [BYTE_W-1:0] ID_AUDIO_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] ID_VIDEO_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] ID_VIDEO_HI = 8'hEF;

    localparam logic [BYTE_W-1:0]  STUFF_BYTE  = 8'hFF;
    localparam logic [STAMP_W-1:0] NO_STAMP    = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0]   HDR_MAX     = 16'hFFFF;
    localparam logic [HDR_W-1:0]   HDR_START   = 16'd4;

    // Nibble codes of the byte that opens a time stamp field.
    localparam logic [3:0] MARK_PTS      = 4'h2;
    localparam logic [3:0] MARK_PTS_DTS  = 4'h3;
    // Top two bits of the first STD buffer byte.
    localparam logic [1:0] STD_PREFIX    = 2'b01;

    // Length and time stamp field sizes in bytes.
    localparam logic [IDX_W-1:0] LEN_BYTES_SHORT = 4'd2;
    localparam logic [IDX_W-1:0] LEN_BYTES_LONG  = 4'd4;
    localparam logic [IDX_W-1:0] STAMP_BYTES     = 4'd5;
    localparam logic [IDX_W-1:0] STAMP2_BYTES    = 4'd10;

    // Fixed part minus five: start code plus id (four) plus the first counted byte.
    localparam logic [PAY_W-1:0] REM_START_SHORT = 32'd1;
    localparam logic [PAY_W-1:0] REM_START_LONG  = 32'd3;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LEN    = 7'b0000010,
        PH_STUFF  = 7'b0000100,
        PH_STD2   = 7'b0001000,
        PH_MARK   = 7'b0010000,
        PH_PTS    = 7'b0100000,
        PH_PTSDTS = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [PAY_W-1:0]   payload_bytes;
        logic [HDR_W-1:0]   header_bytes;
        logic [STAMP_W-1:0] dts;
        logic [STAMP_W-1:0] pts;
        logic [BUF_W-1:0]   buffer_bytes;
        logic [LEN_W-1:0]   packet_length;
        logic [SUB_W-1:0]   substream;
        logic [TYPE_W-1:0]  stream_type;
        logic [BYTE_W-1:0]  pkt_id;
    } result_t;

    // Pulls the low 32 bits of a 33-bit stamp out of its five-byte field.
    function automatic logic [STAMP_W-1:0] decode_stamp(input logic [SHIFT_W-1:0] s);
        return {s[34:33], s[31:17], s[15:1]};
    endfunction

endpackage
`default_nettype wire

// ===== sv/mpes_id_class.sv =====
// Stream id classifier: maps the id byte to a stream type and substream number.
`default_nettype none
module mpes_id_class (
    input  wire logic [mpes_pkg::BYTE_W-1:0] pkt_id,
    output logic      [mpes_pkg::TYPE_W-1:0] stream_type,
    output logic      [mpes_pkg::SUB_W-1:0]  substream
);

    always_comb begin
        if (pkt_id >= mpes_pkg::ID_VIDEO_LO && pkt_id <= mpes_pkg::ID_VIDEO_HI) begin
            stream_type = mpes_pkg::TYPE_VIDEO;
            substream   = {1'b0, pkt_id[3:0]};
        end else if (pkt_id >= mpes_pkg::ID_AUDIO_LO
                     && pkt_id <= mpes_pkg::ID_AUDIO_HI) begin
            stream_type = mpes_pkg::TYPE_AUDIO;
            substream   = pkt_id[4:0];
        end else if (pkt_id == mpes_pkg::ID_PRIVATE1) begin
            stream_type = mpes_pkg::TYPE_PRIVATE;
            substream   = 5'd1;
        end else if (pkt_id == mpes_pkg::ID_PRIVATE2) begin
            stream_type = mpes_pkg::TYPE_PRIVATE;
            substream   = 5'd2;
        end else if (pkt_id == mpes_pkg::ID_PADDING) begin
            stream_type = mpes_pkg::TYPE_PADDING;
            substream   = '0;
        end else begin
            stream_type = mpes_pkg::TYPE_OTHER;
            substream   = '0;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mpes_parse.sv =====
// Header parsing state machine and held fields; produces one result per packet header.
`default_nettype none
module mpes_parse (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [mpes_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic                          starts_header,
    input  wire logic                          short_length,
    output logic                               res_valid,
    output mpes_pkg::result_t                  res
);

    mpes_pkg::phase_t                 phase_reg, phase_next;
    logic [mpes_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [mpes_pkg::BYTE_W-1:0]      id_reg, id_next;
    logic [mpes_pkg::TYPE_W-1:0]      type_reg, type_next;
    logic [mpes_pkg::SUB_W-1:0]       sub_reg, sub_next;
    logic [mpes_pkg::LEN_W-1:0]       length_reg, length_next;
    logic [mpes_pkg::BUF_W-1:0]       buffer_reg, buffer_next;
    logic [mpes_pkg::SHIFT_W-1:0]     shift_reg, shift_next;
    logic [mpes_pkg::STAMP_W-1:0]     pts_reg, pts_next;
    logic [mpes_pkg::STAMP_W-1:0]     dts_reg, dts_next;
    logic [mpes_pkg::HDR_W-1:0]       hdr_reg, hdr_next;
    logic                             short_reg, short_next;
    // Fixed part minus the true header size, one byte ahead of the count.
    logic [mpes_pkg::PAY_W-1:0]       rem_reg, rem_next;

    logic [mpes_pkg::TYPE_W-1:0]      class_type;
    logic [mpes_pkg::SUB_W-1:0]       class_sub;
    logic                             emit;
    logic                             mark_pts;
    logic                             mark_both;
    logic [12:0]                      std_size;

    mpes_id_class u_class (
        .pkt_id      (data_byte),
        .stream_type (class_type),
        .substream   (class_sub)
    );

    assign mark_pts  = (data_byte[7:4] == mpes_pkg::MARK_PTS);
    assign mark_both = (data_byte[7:4] == mpes_pkg::MARK_PTS_DTS);
    assign std_size  = {shift_reg[4:0], data_byte};

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        sub_next    = sub_reg;
        length_next = length_reg;
        buffer_next = buffer_reg;
        shift_next  = shift_reg;
        pts_next    = pts_reg;
        dts_next    = dts_reg;
        hdr_next    = hdr_reg;
        short_next  = short_reg;
        rem_next    = rem_reg;
        emit        = 1'b0;

        if (in_valid) begin
            if (starts_header) begin
                id_next     = data_byte;
                type_next   = class_type;
                sub_next    = class_sub;
                short_next  = short_length;
                length_next = '0;
                hdr_next    = mpes_pkg::HDR_START;
                rem_next    = short_length ? mpes_pkg::REM_START_SHORT
                                           : mpes_pkg::REM_START_LONG;
                idx_next    = '0;
                phase_next  = mpes_pkg::PH_LEN;
            end else if (phase_reg != mpes_pkg::PH_IDLE) begin
                if (hdr_reg != mpes_pkg::HDR_MAX) begin
                    hdr_next = hdr_reg + 16'd1;
                end
                rem_next = rem_reg - 32'd1;

                case (phase_reg)
                    mpes_pkg::PH_LEN: begin
                        length_next = {length_reg[23:0], data_byte};
                        idx_next    = idx_reg + 4'd1;
                        if (idx_next >= (short_reg ? mpes_pkg::LEN_BYTES_SHORT
                                                   : mpes_pkg::LEN_BYTES_LONG)) begin
                            idx_next = '0;
                            if (id_reg == mpes_pkg::ID_PADDING
                                || id_reg == mpes_pkg::ID_PRIVATE2) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = mpes_pkg::PH_STUFF;
                            end
                        end
                    end
                    mpes_pkg::PH_STUFF: begin
                        if (data_byte == mpes_pkg::STUFF_BYTE) begin
                            phase_next = mpes_pkg::PH_STUFF;
                        end else if (data_byte[7:6] == mpes_pkg::STD_PREFIX) begin
                            shift_next = {32'd0, data_byte};
                            phase_next = mpes_pkg::PH_STD2;
                        end else if (mark_pts || mark_both) begin
                            shift_next = {32'd0, data_byte};
                            idx_next   = 4'd1;
                            phase_next = mark_pts ? mpes_pkg::PH_PTS : mpes_pkg::PH_PTSDTS;
                        end else begin
                            pts_next = mpes_pkg::NO_STAMP;
                            dts_next = mpes_pkg::NO_STAMP;
                            emit     = 1'b1;
                        end
                    end
                    mpes_pkg::PH_STD2: begin
                        // Scale bit picks 1024-byte or 128-byte units.
                        buffer_next = shift_reg[5] ? {std_size, 10'd0}
                                                   : {3'd0, std_size, 7'd0};
                        phase_next  = mpes_pkg::PH_MARK;
                    end
                    mpes_pkg::PH_MARK: begin
                        if (mark_pts || mark_both) begin
                            shift_next = {32'd0, data_byte};
                            idx_next   = 4'd1;
                            phase_next = mark_pts ? mpes_pkg::PH_PTS : mpes_pkg::PH_PTSDTS;
                        end else begin
                            pts_next = mpes_pkg::NO_STAMP;
                            dts_next = mpes_pkg::NO_STAMP;
                            emit     = 1'b1;
                        end
                    end
                    mpes_pkg::PH_PTS, mpes_pkg::PH_PTSDTS: begin
                        shift_next = {shift_reg[31:0], data_byte};
                        idx_next   = idx_reg + 4'd1;
                        if (idx_next == mpes_pkg::STAMP_BYTES) begin
                            pts_next = mpes_pkg::decode_stamp(shift_next);
                            if (phase_reg == mpes_pkg::PH_PTS) begin
                                dts_next = mpes_pkg::NO_STAMP;
                                emit     = 1'b1;
                            end
                        end else if (idx_next >= mpes_pkg::STAMP2_BYTES) begin
                            dts_next = mpes_pkg::decode_stamp(shift_next);
                            emit     = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = mpes_pkg::PH_IDLE;
                        idx_next   = '0;
                    end
                endcase

                if (emit) begin
                    phase_next = mpes_pkg::PH_IDLE;
                    idx_next   = '0;
                end
            end
        end
    end

    assign res_valid             = emit;
    assign res.pkt_id            = id_reg;
    assign res.stream_type       = type_reg;
    assign res.substream         = sub_reg;
    assign res.packet_length     = length_next;
    assign res.buffer_bytes      = buffer_next;
    assign res.pts               = pts_next;
    assign res.dts               = dts_next;
    assign res.header_bytes      = hdr_next;
    // rem_reg already accounts for this byte, so one add gives the payload size.
    assign res.payload_bytes     = length_next + rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mpes_pkg::PH_IDLE;
            idx_reg    <= '0;
            id_reg     <= '0;
            type_reg   <= mpes_pkg::TYPE_OTHER;
            sub_reg    <= '0;
            length_reg <= '0;
            buffer_reg <= '0;
            shift_reg  <= '0;
            pts_reg    <= mpes_pkg::NO_STAMP;
            dts_reg    <= mpes_pkg::NO_STAMP;
            hdr_reg    <= '0;
            short_reg  <= 1'b1;
            rem_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            id_reg     <= id_next;
            type_reg   <= type_next;
            sub_reg    <= sub_next;
            length_reg <= length_next;
            buffer_reg <= buffer_next;
            shift_reg  <= shift_next;
            pts_reg    <= pts_next;
            dts_reg    <= dts_next;
            hdr_reg    <= hdr_next;
            short_reg  <= short_next;
            rem_reg    <= rem_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mpeg1_pes_header_parser_core.sv =====
// Top level of the MPEG-1 packet header parser: ports, length mode register, output register.
//
//  Channel  Direction  Payload
//  s_       in         tdata = data_byte, tuser = starts_header
//  m_       out        tdata = header result fields, tuser = stream_type
//  cfg_     in         short_length (1 selects a 16-bit length field)
//
// One header byte is taken per cycle unless stalled; the parser state advances in the cycle
// the byte is accepted; the result is registered in the cycle after the last header byte.
// The output register is the only buffer: a new byte is taken whenever it is empty or
// being drained in the same cycle, so a stalled result holds back the input.
// aresetn is synchronous and active low; it clears the parser and sets the length mode
// to 16 bits.
`default_nettype none
module mpeg1_pes_header_parser_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  wire logic                                s_tuser,  // [0] starts_header
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [7:0] id byte, [12:8] substream, [44:13] packet_length, [67:45] buffer_bytes,
    // [99:68] pts, [131:100] dts, [147:132] header_bytes, [179:148] payload_bytes,
    // [183:180] zero
    output logic [mpes_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [mpes_pkg::TYPE_W-1:0]              m_tuser,  // [2:0] stream_type
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_wdata
);

    logic                                  short_reg;
    logic                                  in_fire;
    logic                                  res_valid;
    mpes_pkg::result_t                     res;
    logic                                  m_valid_reg, m_valid_next;
    logic [mpes_pkg::OUT_DATA_W-1:0]       m_data_reg;
    logic [mpes_pkg::TYPE_W-1:0]           m_user_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    mpes_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_fire),
        .data_byte     (s_tdata),
        .starts_header (s_tuser),
        .short_length  (short_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                short_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {4'd0, res.payload_bytes, res.header_bytes, res.dts, res.pts,
                           res.buffer_bytes, res.packet_length, res.substream, res.pkt_id};
            m_user_reg <= res.stream_type;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire
